// ----- hdl/bcdb_pkg.sv -----
// ----------------------------------------------------------------------------
// bcdb_pkg
// Shared types and constants for the binary to packed BCD byte emitter.
// ----------------------------------------------------------------------------
package bcdb_pkg;

    // default configuration
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_BYTES_DEF  = 8;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 3;
    localparam int DIGIT_W = 4;

    // byte used to fill positions past the digits
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

    // add-3 correction of the shift-and-add-3 conversion
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

    // input item
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] byte_count;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  byte_position;
        logic              last_byte;
    } out_item_t;

endpackage

// ----- hdl/bcdb_cell.sv -----
// ----------------------------------------------------------------------------
// bcdb_cell
// One decimal digit of the conversion chain: corrects by three when the digit
// is five or more, then shifts in the bit from its lower neighbour.
// ----------------------------------------------------------------------------
module bcdb_cell
    import bcdb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               step,
    input  logic               carry_in,
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adjusted;

    // add-3 correction
    assign adjusted  = (digit_reg >= ADJ_LIMIT) ? (digit_reg + ADJ_ADD) : digit_reg;
    assign carry_out = adjusted[DIGIT_W-1];
    assign digit     = digit_reg;

    // shift one bit in per step
    always_comb
    begin
        digit_next = digit_reg;
        if (clear)
        begin
            digit_next = '0;
        end
        else if (step)
        begin
            digit_next = {adjusted[DIGIT_W-2:0], carry_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ----- hdl/binary_to_packed_bcd_bytes_core.sv -----
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_bytes_core
// Converts an unsigned binary value to packed BCD through a row of digit
// cells and emits one byte per buffer position, padded with 0xFF.
// ----------------------------------------------------------------------------
//
//   channel   signals                            direction
//   --------  ---------------------------------  ---------
//   item      item_valid, item_stall, item       into block
//   result    result_valid, result_stall, result out of block
//
// one item is loaded, shifted through the digit chain one bit per cycle,
// sized to its used bytes, then emitted one byte per buffer position.
// reset clears the controller, the cells and the result register.
// result_stall holds the byte in the output register and pauses emission;
// a new item is taken as soon as the last byte sits in that register.
//
module binary_to_packed_bcd_bytes_core
    import bcdb_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_BYTES  = MAX_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NUM_PAIRS  = (NUM_DIGITS + 1) / 2;
    localparam int STEP_W     = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(MAX_BYTES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_SIZE,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   shift_reg, shift_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [IDX_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        emit_reg, emit_next;
    logic [IDX_W-1:0]        used_reg, used_next;
    logic                    res_valid_reg, res_valid_next;
    out_item_t               res_item_reg, res_item_next;

    logic                    accept;
    logic                    out_free;
    logic [IDX_W-1:0]        count_sat;
    logic [VALUE_BITS+VALUE_W-1:0] value_ext;
    logic [DIGIT_W-1:0]      digits [2*NUM_PAIRS];
    logic                    carry [NUM_DIGITS+1];
    logic [NUM_PAIRS-1:0]    pair_nz;
    int                      needed;
    logic [IDX_W-1:0]        pair_sel;
    logic [BYTE_W-1:0]       byte_sel;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_item_reg;

    // value zero-extended then cut to the converter width
    assign value_ext = {{VALUE_BITS{1'b0}}, item.value};

    // saturate the buffer length
    always_comb
    begin
        if (32'(item.byte_count) > 32'(MAX_BYTES))
        begin
            count_sat = IDX_W'(MAX_BYTES);
        end
        else
        begin
            count_sat = IDX_W'(item.byte_count);
        end
    end

    // digit chain, binary msb enters the lowest cell
    assign carry[0] = shift_reg[VALUE_BITS-1];

    for (genvar i = 0; i < 2 * NUM_PAIRS; i++)
    begin : g_digit
        if (i < NUM_DIGITS)
        begin : g_cell
            bcdb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .clear     (accept),
                .step      (state_reg == S_CONVERT),
                .carry_in  (carry[i]),
                .carry_out (carry[i+1]),
                .digit     (digits[i])
            );
        end
        else
        begin : g_blank
            assign digits[i] = '0;
        end
    end

    // nonzero flag per digit pair
    for (genvar p = 0; p < NUM_PAIRS; p++)
    begin : g_pair
        assign pair_nz[p] = (digits[2*p] != '0) || (digits[2*p+1] != '0);
    end

    // bytes the value needs, zero counts as one
    always_comb
    begin
        needed = 1;
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            if (pair_nz[p])
            begin
                needed = p + 1;
            end
        end
    end

    // byte for the current position: pair used-1-index or padding
    assign pair_sel = used_reg - emit_reg - IDX_W'(1);

    always_comb
    begin
        byte_sel = PAD_BYTE;
        if (emit_reg < used_reg)
        begin
            for (int p = 0; p < NUM_PAIRS; p++)
            begin
                if (int'(pair_sel) == p)
                begin
                    byte_sel = {digits[2*p+1], digits[2*p]};
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        used_next      = used_reg;
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;

        // output register drains
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    shift_next = value_ext[VALUE_BITS-1:0];
                    step_next  = '0;
                    count_next = count_sat;
                    emit_next  = '0;
                    state_next = S_CONVERT;
                end
            end
            S_CONVERT:
            begin
                shift_next = shift_reg << 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_BITS - 1))
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                if (int'(count_reg) < needed)
                begin
                    used_next = count_reg;
                end
                else
                begin
                    used_next = IDX_W'(needed);
                end
                if (count_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next               = 1'b1;
                    res_item_next.out_byte       = byte_sel;
                    res_item_next.byte_position  = POS_W'(emit_reg);
                    res_item_next.last_byte      = (emit_reg + IDX_W'(1) == count_reg);
                    emit_next                    = emit_reg + IDX_W'(1);
                    if (emit_reg + IDX_W'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shift_reg     <= '0;
            step_reg      <= '0;
            count_reg     <= '0;
            emit_reg      <= '0;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            used_reg      <= used_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

endmodule
